// ----- design/ioapic_window_and_irq_router_core_macros.svh -----
// Assertion helpers used by the RTL core of the I/O APIC router.
`ifndef IOAPIC_WINDOW_AND_IRQ_ROUTER_CORE_MACROS_SVH
`define IOAPIC_WINDOW_AND_IRQ_ROUTER_CORE_MACROS_SVH

// Implication within the same cycle.
`define IOAPIC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define IOAPIC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ioapic_pkg.sv -----
`default_nettype none

package ioapic_pkg;

  localparam int TABLE_WORDS = 48;
  localparam int NUM_PAIRS   = TABLE_WORDS / 2;
  localparam int PAIR_W      = (NUM_PAIRS > 1) ? $clog2(NUM_PAIRS) : 1;
  localparam int WIDX_W      = $clog2(TABLE_WORDS);

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_IRQ   = 2'd2;

  localparam logic [7:0]  SELECT_OFFSET = 8'h00;
  localparam logic [7:0]  WINDOW_OFFSET = 8'h10;
  localparam logic [31:0] SEL_ID        = 32'd0;
  localparam logic [31:0] SEL_VERSION   = 32'd1;
  localparam logic [31:0] SEL_ARB       = 32'd2;
  localparam logic [31:0] SEL_TABLE     = 32'h10;
  localparam logic [31:0] ID_WORD       = 32'h0;
  localparam logic [31:0] VERSION_WORD  = 32'h0017_0011;
  localparam logic [31:0] ARB_WORD      = 32'h0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PUSH
  } state_e;

  typedef struct packed {
    logic shift;
    logic we_even;
    logic we_odd;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- design/ioapic_chan_if.sv -----
`default_nettype none

interface ioapic_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] bus_offset;
  logic [31:0] write_data;
  logic [7:0] irq_number;

  modport source (output valid, kind, bus_offset, write_data, irq_number, input ready);
  modport sink   (input valid, kind, bus_offset, write_data, irq_number, output ready);
endinterface

interface ioapic_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        deliver;
  logic [7:0]  dest_id;
  logic [7:0]  vector_out;

  modport source (output valid, read_data, deliver, dest_id, vector_out, input ready);
  modport sink   (input valid, read_data, deliver, dest_id, vector_out, output ready);
endinterface

`default_nettype wire

// ----- design/ioapic_window_and_irq_router_core.sv -----
// I/O APIC register window and interrupt router.
// The request channel carries register reads, register writes and interrupt
// requests; the response channel returns exactly one result per request.
// A register read or write offers its result in the cycle right after its
// transfer, and the next request can be taken at the same edge that takes
// that result, so register accesses can run at one per cycle if not stalled.
// The redirection table is a ring of pair cells that holds one even/odd word
// pair each. An interrupt request rotates the ring one pair per cycle past the
// head cell, whose even word is compared with the irq; once all NUM_PAIRS
// pairs (24 by default) have passed the head the ring is back in place and
// the FSM moves to the push state, which loads the result into the output
// register once it is free. No new request is taken between the transfer of
// an interrupt and the edge that takes its result.
// Reset clears the select and window registers and the whole table at once.
// A result waits in the output register while the receiver stalls; a new
// request is taken only when the output register is free or being emptied.
`default_nettype none

`include "ioapic_window_and_irq_router_core_macros.svh"

module ioapic_window_and_irq_router_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ioapic_req_if.sink   req_i,
  ioapic_rsp_if.source rsp_o
);
  import ioapic_pkg::*;

  state_e state_q, state_d;
  logic [PAIR_W-1:0] scan_cnt_d, scan_cnt_q;
  logic [31:0] select_d, select_q;
  logic [31:0] window_d, window_q;
  logic [7:0]  irq_d, irq_q;
  logic        found_d, found_q;
  logic [7:0]  dest_d, dest_q;

  logic        out_valid_d, out_valid_q;
  logic [31:0] out_rdata_d, out_rdata_q;
  logic        out_deliver_d, out_deliver_q;
  logic [7:0]  out_dest_d, out_dest_q;
  logic [7:0]  out_vector_d, out_vector_q;

  logic        slot_free;
  logic        accept;
  logic        scan_active;
  logic        push_load;
  logic        scan_last;
  logic        head_match;
  logic        tbl_write;
  logic [31:0] tbl_off;
  logic [WIDX_W-1:0] wr_idx;
  logic [WIDX_W-1:0] wr_pair;

  logic [31:0] even_w [NUM_PAIRS];
  logic [31:0] odd_w  [NUM_PAIRS];
  cell_ctl_t   ctl_w  [NUM_PAIRS];

  assign slot_free   = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE) && slot_free;
  assign accept      = req_i.valid && req_i.ready;
  assign scan_last   = (scan_cnt_q == PAIR_W'(NUM_PAIRS - 1));
  assign head_match  = (even_w[0] == {24'd0, irq_q});

  assign tbl_off   = select_q - SEL_TABLE;
  assign tbl_write = accept && (req_i.kind == KIND_WRITE) &&
                     (req_i.bus_offset == WINDOW_OFFSET) &&
                     (select_q >= SEL_TABLE) && (tbl_off < 32'(TABLE_WORDS));
  assign wr_idx    = tbl_off[WIDX_W-1:0];
  assign wr_pair   = wr_idx >> 1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (req_i.kind == KIND_IRQ)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    scan_active = 1'b0;
    push_load   = 1'b0;
    case (state_q)
      ST_SCAN: scan_active = 1'b1;
      ST_PUSH: push_load   = slot_free;
      default: begin
        scan_active = 1'b0;
        push_load   = 1'b0;
      end
    endcase
  end

  genvar k;
  generate
    for (k = 0; k < NUM_PAIRS; k++) begin : g_cell
      assign ctl_w[k].shift   = scan_active;
      assign ctl_w[k].we_even = tbl_write && (wr_pair == WIDX_W'(k)) && !wr_idx[0];
      assign ctl_w[k].we_odd  = tbl_write && (wr_pair == WIDX_W'(k)) && wr_idx[0];

      ioapic_pair_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctl_i      (ctl_w[k]),
        .nbr_even_i (even_w[(k + 1) % NUM_PAIRS]),
        .nbr_odd_i  (odd_w[(k + 1) % NUM_PAIRS]),
        .wdata_i    (req_i.write_data),
        .even_o     (even_w[k]),
        .odd_o      (odd_w[k])
      );
    end
  endgenerate

  always_comb begin
    select_d   = select_q;
    window_d   = window_q;
    irq_d      = irq_q;
    scan_cnt_d = scan_cnt_q;
    found_d    = found_q;
    dest_d     = dest_q;

    if (accept && (req_i.kind == KIND_WRITE) && (req_i.bus_offset == SELECT_OFFSET)) begin
      select_d = req_i.write_data;
      if (req_i.write_data == SEL_ID) begin
        window_d = ID_WORD;
      end else if (req_i.write_data == SEL_VERSION) begin
        window_d = VERSION_WORD;
      end else if (req_i.write_data == SEL_ARB) begin
        window_d = ARB_WORD;
      end
    end

    if (accept && (req_i.kind == KIND_IRQ)) begin
      irq_d      = req_i.irq_number;
      scan_cnt_d = '0;
      found_d    = 1'b0;
      dest_d     = '0;
    end else if (scan_active) begin
      scan_cnt_d = scan_cnt_q + PAIR_W'(1);
      if (!found_q && head_match) begin
        found_d = 1'b1;
        dest_d  = odd_w[0][7:0];
      end
    end
  end

  always_comb begin
    out_valid_d   = out_valid_q;
    out_rdata_d   = out_rdata_q;
    out_deliver_d = out_deliver_q;
    out_dest_d    = out_dest_q;
    out_vector_d  = out_vector_q;
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (accept && (req_i.kind != KIND_IRQ)) begin
      out_valid_d   = 1'b1;
      out_rdata_d   = ((req_i.kind == KIND_READ) && (req_i.bus_offset == WINDOW_OFFSET)) ?
                      window_q : 32'd0;
      out_deliver_d = 1'b0;
      out_dest_d    = '0;
      out_vector_d  = '0;
    end else if (push_load) begin
      out_valid_d   = 1'b1;
      out_rdata_d   = '0;
      out_deliver_d = 1'b1;
      out_dest_d    = dest_q;
      out_vector_d  = irq_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_cnt_q  <= '0;
      select_q    <= '0;
      window_q    <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_cnt_q  <= scan_cnt_d;
      select_q    <= select_d;
      window_q    <= window_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    irq_q         <= irq_d;
    dest_q        <= dest_d;
    out_rdata_q   <= out_rdata_d;
    out_deliver_q <= out_deliver_d;
    out_dest_q    <= out_dest_d;
    out_vector_q  <= out_vector_d;
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.read_data  = out_rdata_q;
  assign rsp_o.deliver    = out_deliver_q;
  assign rsp_o.dest_id    = out_dest_q;
  assign rsp_o.vector_out = out_vector_q;

  `IOAPIC_ASSERT_NXT(a_irq_starts_scan, clk_i, rst_ni,
    accept && (req_i.kind == KIND_IRQ), (state_q == ST_SCAN) && (scan_cnt_q == '0),
    "An accepted interrupt request did not start a table scan.")

  `IOAPIC_ASSERT_NXT(a_scan_ends_in_push, clk_i, rst_ni,
    (state_q == ST_SCAN) && scan_last, state_q == ST_PUSH,
    "The table scan did not end after one full rotation.")

  `IOAPIC_ASSERT_NXT(a_push_delivers, clk_i, rst_ni,
    push_load, (state_q == ST_IDLE) && out_valid_q && out_deliver_q,
    "The interrupt result was not placed in the output register.")

  `IOAPIC_ASSERT_IMP(a_found_only_in_scan, clk_i, rst_ni,
    $rose(found_q), $past(state_q) == ST_SCAN,
    "A table match was recorded outside a scan.")

endmodule

`default_nettype wire

// ----- design/ioapic_pair_cell.sv -----
`default_nettype none

module ioapic_pair_cell (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ioapic_pkg::cell_ctl_t ctl_i,
  input  wire logic [31:0]           nbr_even_i,
  input  wire logic [31:0]           nbr_odd_i,
  input  wire logic [31:0]           wdata_i,
  output logic [31:0]                even_o,
  output logic [31:0]                odd_o
);
  import ioapic_pkg::*;

  logic [31:0] even_d, even_q;
  logic [31:0] odd_d, odd_q;

  always_comb begin
    even_d = even_q;
    odd_d  = odd_q;
    if (ctl_i.shift) begin
      even_d = nbr_even_i;
      odd_d  = nbr_odd_i;
    end else begin
      if (ctl_i.we_even) begin
        even_d = wdata_i;
      end
      if (ctl_i.we_odd) begin
        odd_d = wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      even_q <= '0;
      odd_q  <= '0;
    end else begin
      even_q <= even_d;
      odd_q  <= odd_d;
    end
  end

  assign even_o = even_q;
  assign odd_o  = odd_q;

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
module testbench;
  import ioapic_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 40;
  localparam int QUIET_LIMIT  = 2000;

  typedef struct packed {
    logic [31:0] read_data;
    logic        deliver;
    logic [7:0]  dest_id;
    logic [7:0]  vector_out;
  } rsp_t;

  logic clk;
  logic rst_n;

  ioapic_req_if req_if ();
  ioapic_rsp_if rsp_if ();

  ioapic_window_and_irq_router_core u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  logic [31:0] sel_mirror;
  logic [31:0] win_mirror;
  logic [31:0] tbl_mirror [TABLE_WORDS];

  rsp_t pending_rsp [$];
  int   errors;
  int   quiet_cycles;
  bit   idle_en;
  bit   hold_rsp;
  int   stall_left;

  initial begin
    clk = 1'b0;
  end

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // Updates the mirrored registers and table and returns the expected response.
  function automatic rsp_t compute_response(logic [1:0] kind, logic [7:0] off,
                                            logic [31:0] data, logic [7:0] irq);
    rsp_t        r;
    logic [31:0] idx;
    logic        hit;
    r   = '0;
    hit = 1'b0;
    case (kind)
      KIND_READ: begin
        if (off == WINDOW_OFFSET) begin
          r.read_data = win_mirror;
        end
      end
      KIND_WRITE: begin
        if (off == SELECT_OFFSET) begin
          sel_mirror = data;
          if (data == SEL_ID) begin
            win_mirror = ID_WORD;
          end else if (data == SEL_VERSION) begin
            win_mirror = VERSION_WORD;
          end else if (data == SEL_ARB) begin
            win_mirror = ARB_WORD;
          end
        end else if (off == WINDOW_OFFSET && sel_mirror >= SEL_TABLE) begin
          idx = sel_mirror - SEL_TABLE;
          if (idx < 32'(TABLE_WORDS)) begin
            tbl_mirror[idx] = data;
          end
        end
      end
      KIND_IRQ: begin
        r.deliver    = 1'b1;
        r.vector_out = irq;
        for (int i = 0; i + 1 < TABLE_WORDS; i += 2) begin
          if (!hit && tbl_mirror[i] == {24'h0, irq}) begin
            hit       = 1'b1;
            r.dest_id = tbl_mirror[i + 1][7:0];
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_req(logic [1:0] kind, logic [7:0] off, logic [31:0] data,
                          logic [7:0] irq);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid      = 1'b1;
    req_if.kind       = kind;
    req_if.bus_offset = off;
    req_if.write_data = data;
    req_if.irq_number = irq;
    do begin
      @(posedge clk);
    end while (!req_if.ready);
    pending_rsp.push_back(compute_response(kind, off, data, irq));
    @(negedge clk);
  endtask

  task automatic write_reg(logic [7:0] off, logic [31:0] data);
    send_req(KIND_WRITE, off, data, 8'($urandom));
  endtask

  task automatic read_reg(logic [7:0] off);
    send_req(KIND_READ, off, $urandom, 8'($urandom));
  endtask

  task automatic raise_irq(logic [7:0] irq);
    send_req(KIND_IRQ, 8'($urandom), $urandom, irq);
  endtask

  task automatic program_pair(int pair, logic [31:0] even_word, logic [31:0] odd_word);
    write_reg(SELECT_OFFSET, SEL_TABLE + 32'(2 * pair));
    write_reg(WINDOW_OFFSET, even_word);
    write_reg(SELECT_OFFSET, SEL_TABLE + 32'(2 * pair + 1));
    write_reg(WINDOW_OFFSET, odd_word);
  endtask

  task automatic test_directed();
    // A cleared table matches irq zero in the first pair.
    raise_irq(8'h00);
    read_reg(WINDOW_OFFSET);
    write_reg(SELECT_OFFSET, SEL_VERSION);
    read_reg(WINDOW_OFFSET);
    // A select between the fixed words and the table leaves the window alone.
    write_reg(SELECT_OFFSET, 32'h5);
    read_reg(WINDOW_OFFSET);
    write_reg(SELECT_OFFSET, SEL_ID);
    read_reg(WINDOW_OFFSET);
    write_reg(SELECT_OFFSET, SEL_ARB);
    read_reg(WINDOW_OFFSET);
    program_pair(NUM_PAIRS - 1, 32'h55, 32'hFFFF_FFA7);
    // Window writes past the end of the table must be dropped.
    write_reg(SELECT_OFFSET, SEL_TABLE + 32'(TABLE_WORDS));
    write_reg(WINDOW_OFFSET, 32'h55);
    write_reg(SELECT_OFFSET, 32'hFFFF_FFFF);
    write_reg(WINDOW_OFFSET, 32'h99);
    write_reg(8'h20, $urandom);
    read_reg(SELECT_OFFSET);
    read_reg(8'hFF);
    send_req(KIND_UNUSED, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
    raise_irq(8'h55);
    raise_irq(8'hFF);
  endtask

  task automatic test_routing(int rounds);
    int          action;
    int          pair;
    logic [31:0] even_word;
    logic [31:0] sel;
    logic [1:0]  kind;
    for (int n = 0; n < rounds; n++) begin
      action = $urandom_range(0, 9);
      pair   = $urandom_range(0, NUM_PAIRS - 1);
      if (action <= 3) begin
        even_word = ($urandom_range(0, 3) != 0) ? {24'h0, 8'($urandom)} : $urandom;
        program_pair(pair, even_word, $urandom);
        raise_irq(even_word[7:0]);
      end else if (action <= 6) begin
        if ($urandom_range(0, 9) < 7) begin
          raise_irq(tbl_mirror[2 * pair][7:0]);
        end else begin
          raise_irq(8'($urandom));
        end
      end else if (action == 7) begin
        write_reg(SELECT_OFFSET, 32'($urandom_range(0, 2)));
        read_reg(WINDOW_OFFSET);
      end else if (action == 8) begin
        case ($urandom_range(0, 2))
          0: sel = 32'($urandom_range(3, 15));
          1: sel = SEL_TABLE + 32'($urandom_range(0, TABLE_WORDS + 15));
          default: sel = $urandom;
        endcase
        write_reg(SELECT_OFFSET, sel);
        write_reg(WINDOW_OFFSET, $urandom);
        read_reg(WINDOW_OFFSET);
      end else begin
        kind = ($urandom_range(0, 15) == 0) ? KIND_UNUSED : 2'($urandom_range(0, 2));
        send_req(kind, 8'($urandom), $urandom, 8'($urandom));
      end
    end
  endtask

  task automatic test_backpressure();
    bit saved_idle;
    saved_idle = idle_en;
    idle_en    = 1'b0;
    hold_rsp   = 1'b1;
    for (int n = 0; n < 12; n++) begin
      if (n % 3 == 0) begin
        raise_irq(tbl_mirror[2 * $urandom_range(0, NUM_PAIRS - 1)][7:0]);
      end else begin
        read_reg(WINDOW_OFFSET);
      end
    end
    idle_en = saved_idle;
  endtask

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: response with none expected: read_data %h deliver %b dest %h vec %h",
                 $time, rsp_if.read_data, rsp_if.deliver, rsp_if.dest_id,
                 rsp_if.vector_out);
        errors++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        check_field("read_data", exp_rsp.read_data, rsp_if.read_data);
        check_field("deliver", 32'(exp_rsp.deliver), 32'(rsp_if.deliver));
        check_field("dest_id", 32'(exp_rsp.dest_id), 32'(rsp_if.dest_id));
        check_field("vector_out", 32'(exp_rsp.vector_out), 32'(rsp_if.vector_out));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rsp_if.ready = 1'b0;
    stall_left   = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_rsp) begin
        rsp_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_rsp = 1'b0;
      end
      if (stall_left > 0) begin
        rsp_if.ready = 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready = 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    req_if.valid      = 1'b0;
    req_if.kind       = KIND_READ;
    req_if.bus_offset = '0;
    req_if.write_data = '0;
    req_if.irq_number = '0;
    errors            = 0;
    quiet_cycles      = 0;
    idle_en           = 1'b1;
    hold_rsp          = 1'b0;
    sel_mirror        = '0;
    win_mirror        = '0;
    for (int i = 0; i < TABLE_WORDS; i++) begin
      tbl_mirror[i] = '0;
    end
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_routing(120);
    test_backpressure();
    idle_en = 1'b0;
    test_routing(40);
    idle_en = 1'b1;
    test_routing(120);
    req_if.valid = 1'b0;

    while (pending_rsp.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/ioapic_pkg.sv
design/ioapic_chan_if.sv
design/ioapic_pair_cell.sv
design/ioapic_window_and_irq_router_core.sv
sim/testbench.sv
